@@ design/arw_pkg.sv @@
package arw_pkg;

    localparam int PATTERN_MAX_DEFAULT = 16;
    localparam int BUFFER_SIZE_DEFAULT = 512;

    localparam int PATTERN_REG_BYTES = 16;
    localparam int ERR_LEN = 5;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [1:0] CFG_PATTERN_LENGTH = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd3;

    localparam logic [1:0] IDLE_BUSY     = 2'd0;
    localparam logic [1:0] IDLE_IDLE     = 2'd1;
    localparam logic [1:0] IDLE_FINISHED = 2'd2;

    localparam logic [63:0] PATTERN_LOW_RESET    = 64'h0000_0000_0000_4B4F;
    localparam logic [63:0] PATTERN_HIGH_RESET   = 64'h0;
    localparam logic [4:0]  PATTERN_LENGTH_RESET = 5'd2;
    localparam logic [31:0] TIMEOUT_TICKS_RESET  = 32'd1000;

    localparam logic [7:0] ERR_WORD [ERR_LEN] = '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_BUSY    = 3'd1,
        ST_OK      = 3'd2,
        ST_ERROR   = 3'd3,
        ST_TIMEOUT = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       start_accepted;
        logic [1:0] idle_code;
    } result_t;

    typedef struct packed {
        logic pattern_hit;
        logic error_hit;
    } match_t;

endpackage

@@ design/arw_matcher.sv @@
module arw_matcher #(
    parameter int PATTERN_MAX = arw_pkg::PATTERN_MAX_DEFAULT,
    parameter int COUNT_W = $clog2(arw_pkg::BUFFER_SIZE_DEFAULT)
) (
    input  logic [PATTERN_MAX-1:0][7:0] window,
    input  logic [COUNT_W-1:0]          count,
    input  logic [63:0]                 pattern_low,
    input  logic [63:0]                 pattern_high,
    input  logic [4:0]                  pattern_length,
    output arw_pkg::match_t             match
);
    import arw_pkg::*;

    localparam int LMAX = (PATTERN_MAX < PATTERN_REG_BYTES) ? PATTERN_MAX : PATTERN_REG_BYTES;
    localparam int IDX_W = $clog2(LMAX);
    localparam int CMP_W = (COUNT_W > 5) ? COUNT_W : 5;

    logic [PATTERN_REG_BYTES-1:0][7:0] pat;
    logic [LMAX-1:0] len_hit;
    logic [4:0] eff_len;
    logic [IDX_W-1:0] sel;
    logic [ERR_LEN-1:0] err_eq;
    logic [CMP_W-1:0] count_ext;

    assign pat = {pattern_high, pattern_low};

    for (genvar l = 1; l <= LMAX; l++) begin : g_len
        logic [l-1:0] eq;
        for (genvar i = 0; i < l; i++) begin : g_byte
            assign eq[i] = (window[l-1-i] == pat[i]);
        end
        assign len_hit[l-1] = &eq;
    end

    for (genvar i = 0; i < ERR_LEN; i++) begin : g_err
        assign err_eq[i] = (window[ERR_LEN-1-i] == ERR_WORD[i]);
    end

    always_comb
    begin
        if (pattern_length == 5'd0)
        begin
            eff_len = 5'd1;
        end
        else if (32'(pattern_length) > LMAX)
        begin
            eff_len = 5'(LMAX);
        end
        else
        begin
            eff_len = pattern_length;
        end
    end

    assign sel = IDX_W'(eff_len - 5'd1);
    assign count_ext = CMP_W'(count);

    assign match.pattern_hit = len_hit[sel] && (count_ext >= CMP_W'(eff_len));
    assign match.error_hit = (&err_eq) && (count_ext >= CMP_W'(ERR_LEN));

endmodule

@@ design/at_response_watcher.sv @@
// Watches the reply stream of a modem after a command has been started.
// Items arrive on the item channel (item_valid, item_stall, item): a start
// command, a received byte or a one millisecond tick. Every accepted item
// yields exactly one transfer on the result channel (result_valid,
// result_stall, result) carrying the status after that item, whether a start
// was taken, and an idle code.
// An item is captured in an input register, and from there the single
// pass of window shift, pattern compare and tick update writes the result
// register, which drives result_valid and result.
// One item is accepted every cycle while item_stall is low; the per-item work
// is a parallel compare of the byte window against every pattern length.
// When the receiver stalls, the result register holds, the input register
// fills, and then item_stall rises until the result is taken.
// Configuration is written through cfg_write, cfg_index and cfg_data; the
// user must write it only while the block is idle, as the block itself
// does not enforce this. Reset clears both pipeline registers, returns the
// configuration to its defaults (pattern "OK", length 2, 1000 ticks), and
// leaves the watcher idle with an empty receive window.
module at_response_watcher #(
    parameter int PATTERN_MAX = arw_pkg::PATTERN_MAX_DEFAULT,
    parameter int BUFFER_SIZE = arw_pkg::BUFFER_SIZE_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  arw_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output arw_pkg::result_t result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_data
);
    import arw_pkg::*;

    localparam int COUNT_W = $clog2(BUFFER_SIZE);

    logic in_valid_reg;
    item_t in_item_reg;
    logic res_valid_reg;
    result_t res_reg;
    result_t res_next;

    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [4:0] pattern_length_reg;
    logic [31:0] timeout_reg;

    status_t status_reg;
    status_t status_next;
    logic [PATTERN_MAX-1:0][7:0] window_reg;
    logic [PATTERN_MAX-1:0][7:0] window_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic zero_seen_reg;
    logic zero_seen_next;
    logic [31:0] elapsed_reg;
    logic [31:0] elapsed_next;

    logic adv_out;
    logic adv_in;
    logic fire;
    logic accepted;
    logic [PATTERN_MAX-1:0][7:0] window_shift;
    logic [COUNT_W-1:0] count_inc;
    logic [31:0] elapsed_inc;
    match_t match;

    assign adv_out = !res_valid_reg || !result_stall;
    assign adv_in = !in_valid_reg || adv_out;
    assign fire = in_valid_reg && adv_out;
    assign item_stall = !adv_in;
    assign result_valid = res_valid_reg;
    assign result = res_reg;

    assign window_shift = {window_reg[PATTERN_MAX-2:0], in_item_reg.rx_byte};
    assign count_inc = count_reg + 1'b1;
    assign elapsed_inc = (elapsed_reg != 32'hFFFF_FFFF) ? elapsed_reg + 32'd1 : elapsed_reg;

    arw_matcher #(
        .PATTERN_MAX(PATTERN_MAX),
        .COUNT_W(COUNT_W)
    ) u_matcher (
        .window(window_shift),
        .count(count_inc),
        .pattern_low(pattern_low_reg),
        .pattern_high(pattern_high_reg),
        .pattern_length(pattern_length_reg),
        .match(match)
    );

    always_comb
    begin
        status_next = status_reg;
        window_next = window_reg;
        count_next = count_reg;
        zero_seen_next = zero_seen_reg;
        elapsed_next = elapsed_reg;
        accepted = 1'b0;
        unique case (in_item_reg.operation)
            OP_START:
            begin
                if (status_reg != ST_BUSY)
                begin
                    window_next = '0;
                    count_next = '0;
                    zero_seen_next = 1'b0;
                    elapsed_next = '0;
                    status_next = ST_BUSY;
                    accepted = 1'b1;
                end
            end
            OP_BYTE:
            begin
                if (count_reg >= COUNT_W'(BUFFER_SIZE - 1))
                begin
                    window_next = '0;
                    count_next = '0;
                    zero_seen_next = 1'b0;
                end
                else
                begin
                    count_next = count_inc;
                    if (!zero_seen_reg)
                    begin
                        if (in_item_reg.rx_byte == 8'd0)
                        begin
                            zero_seen_next = 1'b1;
                        end
                        else
                        begin
                            window_next = window_shift;
                            if (status_reg == ST_BUSY)
                            begin
                                if (match.pattern_hit)
                                begin
                                    status_next = ST_OK;
                                end
                                else if (match.error_hit)
                                begin
                                    status_next = ST_ERROR;
                                end
                            end
                        end
                    end
                end
            end
            OP_TICK:
            begin
                if (status_reg == ST_BUSY)
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc >= timeout_reg)
                    begin
                        status_next = ST_TIMEOUT;
                    end
                end
            end
            default:
            begin
            end
        endcase

        res_next.status = status_next;
        res_next.start_accepted = accepted;
        if (status_next == ST_BUSY)
        begin
            res_next.idle_code = IDLE_BUSY;
        end
        else if (status_next == ST_IDLE)
        begin
            res_next.idle_code = IDLE_IDLE;
        end
        else
        begin
            res_next.idle_code = IDLE_FINISHED;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
            status_reg <= ST_IDLE;
            window_reg <= '0;
            count_reg <= '0;
            zero_seen_reg <= 1'b0;
            elapsed_reg <= '0;
        end
        else
        begin
            if (adv_in)
            begin
                in_valid_reg <= item_valid;
            end
            if (adv_out)
            begin
                res_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                status_reg <= status_next;
                window_reg <= window_next;
                count_reg <= count_next;
                zero_seen_reg <= zero_seen_next;
                elapsed_reg <= elapsed_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && item_valid)
        begin
            in_item_reg <= item;
        end
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg <= PATTERN_LOW_RESET;
            pattern_high_reg <= PATTERN_HIGH_RESET;
            pattern_length_reg <= PATTERN_LENGTH_RESET;
            timeout_reg <= TIMEOUT_TICKS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_PATTERN_LOW:    pattern_low_reg <= cfg_data;
                CFG_PATTERN_HIGH:   pattern_high_reg <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[4:0];
                CFG_TIMEOUT_TICKS:  timeout_reg <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

@@ tb/arw_reply_checker.sv @@
`timescale 1ns / 100ps

module arw_reply_checker #(
    parameter int PATTERN_MAX = arw_pkg::PATTERN_MAX_DEFAULT,
    parameter int BUFFER_SIZE = arw_pkg::BUFFER_SIZE_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  logic             item_stall,
    input  arw_pkg::item_t   item,
    input  logic             result_valid,
    input  logic             result_stall,
    input  arw_pkg::result_t result,
    input  logic             cfg_write,
    input  logic [1:0]       cfg_index,
    input  logic [63:0]      cfg_data,
    output int               error_count,
    output int               pending,
    output int               checked
);
    import arw_pkg::*;

    logic [63:0] pat_low;
    logic [63:0] pat_high;
    logic [4:0]  pat_len;
    logic [31:0] tick_limit;

    status_t     cmd_status;
    logic [7:0]  window [PATTERN_MAX];
    logic [$clog2(BUFFER_SIZE)-1:0] byte_count;
    logic        zero_seen;
    logic [31:0] elapsed;

    result_t     reply_forecast [$];
    int          errs;
    int          seen;

    function automatic int active_length();
        int n;
        n = pat_len;
        if (n == 0)
            n = 1;
        if (n > PATTERN_REG_BYTES)
            n = PATTERN_REG_BYTES;
        if (n > PATTERN_MAX)
            n = PATTERN_MAX;
        return n;
    endfunction

    function automatic logic [7:0] pattern_char(int i);
        if (i < 8)
            return pat_low[8*i +: 8];
        return pat_high[8*(i-8) +: 8];
    endfunction

    function automatic bit tail_is_pattern();
        int n;
        int i;
        n = active_length();
        if (byte_count < n)
            return 1'b0;
        for (i = 0; i < n; i++)
        begin
            if (window[n-1-i] != pattern_char(i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic bit tail_is_error();
        int i;
        if (byte_count < ERR_LEN)
            return 1'b0;
        for (i = 0; i < ERR_LEN; i++)
        begin
            if (window[ERR_LEN-1-i] != ERR_WORD[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_window();
        int i;
        for (i = 0; i < PATTERN_MAX; i++)
            window[i] = 8'h00;
        byte_count = '0;
        zero_seen = 1'b0;
    endfunction

    function automatic void take_byte(logic [7:0] b);
        int i;
        if (byte_count >= BUFFER_SIZE - 1)
        begin
            clear_window();
            return;
        end
        byte_count = byte_count + 1'b1;
        if (zero_seen)
            return;
        if (b == 8'h00)
        begin
            zero_seen = 1'b1;
            return;
        end
        for (i = PATTERN_MAX - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = b;
        if (cmd_status != ST_BUSY)
            return;
        if (tail_is_pattern())
            cmd_status = ST_OK;
        else if (tail_is_error())
            cmd_status = ST_ERROR;
    endfunction

    function automatic result_t watch_step(item_t it);
        result_t r;
        r.start_accepted = 1'b0;
        case (it.operation)
            OP_START:
            begin
                if (cmd_status != ST_BUSY)
                begin
                    clear_window();
                    elapsed = '0;
                    cmd_status = ST_BUSY;
                    r.start_accepted = 1'b1;
                end
            end
            OP_BYTE:
                take_byte(it.rx_byte);
            OP_TICK:
            begin
                if (cmd_status == ST_BUSY)
                begin
                    if (elapsed != '1)
                        elapsed = elapsed + 1'b1;
                    if (elapsed >= tick_limit)
                        cmd_status = ST_TIMEOUT;
                end
            end
            default:
                ;
        endcase
        r.status = cmd_status;
        if (cmd_status == ST_BUSY)
            r.idle_code = IDLE_BUSY;
        else if (cmd_status == ST_IDLE)
            r.idle_code = IDLE_IDLE;
        else
            r.idle_code = IDLE_FINISHED;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        result_t got;
        if (!rst_n)
        begin
            pat_low = PATTERN_LOW_RESET;
            pat_high = PATTERN_HIGH_RESET;
            pat_len = PATTERN_LENGTH_RESET;
            tick_limit = TIMEOUT_TICKS_RESET;
            cmd_status = ST_IDLE;
            clear_window();
            elapsed = '0;
            reply_forecast.delete();
            errs = 0;
            seen = 0;
            error_count <= 0;
            pending <= 0;
            checked <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PATTERN_LOW:    pat_low = cfg_data;
                    CFG_PATTERN_HIGH:   pat_high = cfg_data;
                    CFG_PATTERN_LENGTH: pat_len = cfg_data[4:0];
                    CFG_TIMEOUT_TICKS:  tick_limit = cfg_data[31:0];
                    default:            ;
                endcase
            end
            if (result_valid && !result_stall)
            begin
                got = result;
                if (reply_forecast.size() == 0)
                begin
                    $error("result transfer with nothing expected: status %0d", got.status);
                    errs++;
                end
                else
                begin
                    want = reply_forecast.pop_front();
                    seen++;
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        errs++;
                    end
                    if (got.start_accepted !== want.start_accepted)
                    begin
                        $error("start_accepted: expected %0d, actual %0d",
                               want.start_accepted, got.start_accepted);
                        errs++;
                    end
                    if (got.idle_code !== want.idle_code)
                    begin
                        $error("idle_code: expected %0d, actual %0d",
                               want.idle_code, got.idle_code);
                        errs++;
                    end
                end
            end
            if (item_valid && !item_stall)
                reply_forecast.push_back(watch_step(item));
            error_count <= errs;
            pending <= reply_forecast.size();
            checked <= seen;
        end
    end

endmodule

@@ tb/tb_at_response_watcher.sv @@
`timescale 1ns / 100ps

module tb_at_response_watcher;
    import arw_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    item_t       item;
    logic        result_valid;
    logic        result_stall;
    result_t     result;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    int          error_count;
    int          pending;
    int          checked;

    bit          steady;
    bit          hold_req;
    int          items_sent;
    int          settings_used;
    logic [7:0]  pat [PATTERN_REG_BYTES];
    int          pat_n;
    string       pool;

    at_response_watcher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    arw_reply_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .error_count  (error_count),
        .pending      (pending),
        .checked      (checked)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                hold_left = 80;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                result_stall <= 1'b1;
                hold_left--;
            end
            else if (steady)
                result_stall <= 1'b0;
            else
                result_stall <= ($urandom_range(99) < 31);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] value);
        item_t next;
        next.operation = op;
        next.rx_byte = value;
        while (!steady && $urandom_range(99) < 31)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= next;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_item(OP_BYTE, s[i]);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic load_settings(input logic [63:0] lo, input logic [63:0] hi,
                                 input logic [4:0] len, input logic [31:0] ticks);
        logic [63:0] values [4];
        int i;
        values[0] = lo;
        values[1] = hi;
        values[2] = {59'd0, len};
        values[3] = {32'd0, ticks};
        drain();
        for (i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= i[1:0];
            cfg_data <= values[i];
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        for (i = 0; i < PATTERN_REG_BYTES; i++)
            pat[i] = (i < 8) ? lo[8*i +: 8] : hi[8*(i-8) +: 8];
        pat_n = (len == 0) ? 1 : (len > PATTERN_REG_BYTES) ? PATTERN_REG_BYTES : len;
        settings_used++;
    endtask

    task automatic load_random_settings(input int phase);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  len;
        logic [31:0] ticks;
        logic [7:0]  c;
        int i;
        for (i = 0; i < PATTERN_REG_BYTES; i++)
        begin
            c = ($urandom_range(9) == 0) ? 8'($urandom) : pool[$urandom_range(pool.len() - 1)];
            if (i < 8)
                lo[8*i +: 8] = c;
            else
                hi[8*(i-8) +: 8] = c;
        end
        len = 5'($urandom_range(1, 6));
        ticks = 32'($urandom_range(1, 40));
        case (phase)
            0:
            begin
                lo = '1;
                hi = '1;
                len = 5'd16;
                ticks = '1;
            end
            1:
            begin
                len = 5'd31;
                ticks = '0;
            end
            3:
                ticks = '1;
            5:
            begin
                len = 5'd0;
                ticks = 32'd1;
            end
            6:
            begin
                lo = {$urandom, $urandom};
                hi = {$urandom, $urandom};
                len = 5'($urandom);
                ticks = 32'd1000;
            end
            default:
                ;
        endcase
        load_settings(lo, hi, len, ticks);
    endtask

    task automatic random_phase(input int n_items);
        int quota;
        int pick;
        int k;
        quota = items_sent + n_items;
        while (items_sent < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_item(OP_START, 8'($urandom));
            else if (pick < 40)
            begin
                for (k = 0; k < pat_n; k++)
                begin
                    if ($urandom_range(19) == 0)
                        send_item(OP_BYTE, pool[$urandom_range(pool.len() - 1)]);
                    else
                        send_item(OP_BYTE, pat[k]);
                end
            end
            else if (pick < 48)
                send_text("ERROR");
            else if (pick < 65)
            begin
                if ($urandom_range(1))
                    send_item(OP_BYTE, pat[$urandom_range(pat_n - 1)]);
                else
                    send_item(OP_BYTE, pool[$urandom_range(pool.len() - 1)]);
            end
            else if (pick < 68)
                send_item(OP_BYTE, 8'h00);
            else if (pick < 74)
                send_item(OP_BYTE, 8'($urandom));
            else if (pick < 96)
                send_item(OP_TICK, 8'($urandom));
            else
                send_item(OP_UNUSED, 8'($urandom));
        end
    endtask

    initial
    begin
        int p;
        int k;
        pool = "OK\r\nERCONNECT+:";
        items_sent = 0;
        settings_used = 0;
        steady <= 1'b0;
        hold_req <= 1'b0;
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_settings(PATTERN_LOW_RESET, PATTERN_HIGH_RESET, PATTERN_LENGTH_RESET,
                      TIMEOUT_TICKS_RESET);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_TICK, 8'h00);
        send_item(OP_UNUSED, 8'hFF);
        send_item(OP_START, 8'h00);
        send_item(OP_START, 8'h00);
        send_text("OK");
        send_item(OP_START, 8'h00);
        send_text("ERROR");
        send_item(OP_START, 8'h00);
        send_item(OP_BYTE, 8'h00);
        send_text("OK");
        send_item(OP_TICK, 8'h00);

        load_settings(64'h0000_0052_4F52_5245, 64'h0, 5'd5, 32'd0);
        send_item(OP_START, 8'h00);
        send_text("ERROR");
        send_item(OP_START, 8'h00);
        send_item(OP_TICK, 8'h00);

        for (p = 0; p < 8; p++)
        begin
            load_random_settings(p);
            steady <= (p == 4);
            if (p == 2)
                hold_req <= 1'b1;
            if (p == 3)
            begin
                send_item(OP_START, 8'h00);
                for (k = 0; k < 520; k++)
                    send_item(OP_BYTE, pool[$urandom_range(pool.len() - 1)]);
            end
            random_phase(200);
        end

        drain();
        repeat (5)
            @(posedge clk);
        $display("Run covered %0d items under %0d register settings, %0d results checked.",
                 items_sent, settings_used, checked);
        if (error_count == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ sim.f @@
design/arw_pkg.sv
design/arw_matcher.sv
design/at_response_watcher.sv
tb/arw_reply_checker.sv
tb/tb_at_response_watcher.sv
